FILE: hdl/i2c_me_pkg.sv
`timescale 1ns / 1ps

package i2c_me_pkg;

    // Operation codes; a request's func field uses the same codes.
    typedef enum logic [2:0] {
        OP_IDLE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4
    } op_t;

    localparam int FUNC_W = 3;
    localparam int BYTE_W = 8;
    localparam int TICK_W = 5;

    // Slot numbers inside a byte operation.
    localparam logic [TICK_W-1:0] TICK_ACK_LOW  = 5'd16;
    localparam logic [TICK_W-1:0] TICK_ACK_HIGH = 5'd17;
    localparam logic [TICK_W-1:0] TICK_FIRST    = 5'd0;

    // One result of the engine.
    typedef struct packed {
        logic              scl_level;
        logic              sda_drive;
        logic              sda_level;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] rx_byte;
        logic              ack_received;
        logic              cmd_rejected;
    } res_t;

endpackage

FILE: hdl/i2c_me_core.sv
`timescale 1ns / 1ps

module i2c_me_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic [i2c_me_pkg::FUNC_W-1:0] func,
    input  logic [i2c_me_pkg::BYTE_W-1:0] tx_byte,
    input  logic                        ack_to_send,
    input  logic                        sda_sample,
    output i2c_me_pkg::res_t            res
);
    import i2c_me_pkg::*;

    op_t               op_reg, op_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [BYTE_W-1:0] shift_reg, shift_next;
    logic              ack_hold_reg, ack_hold_next;
    logic              last_ack_reg, last_ack_next;
    logic              scl_reg, scl_next;
    logic              sda_reg, sda_next;
    logic              drive_reg, drive_next;
    logic [BYTE_W-1:0] rx_reg, rx_next;

    logic              is_cmd;
    op_t               slot_op;
    logic [TICK_W-1:0] slot_t;
    logic [BYTE_W-1:0] shift_cur;
    logic              ack_cur;
    logic [2:0]        bitpos;
    logic              last_slot;
    logic              busy;
    logic              rejected;

    assign is_cmd = (func == OP_START) || (func == OP_STOP) ||
                    (func == OP_WRITE) || (func == OP_READ);

    // Load a new command when idle; flag a command that arrives while busy.
    always_comb begin
        slot_op   = op_reg;
        slot_t    = tick_reg;
        shift_cur = shift_reg;
        ack_cur   = ack_hold_reg;
        rejected  = 1'b0;
        if (op_reg == OP_IDLE) begin
            if (is_cmd) begin
                slot_op = op_t'(func);
                slot_t  = TICK_FIRST;
                if (func == OP_WRITE) begin
                    shift_cur = tx_byte;
                end
                if (func == OP_READ) begin
                    shift_cur = '0;
                    ack_cur   = ack_to_send;
                end
            end
        end else if (is_cmd) begin
            rejected = 1'b1;
        end
    end

    // Bit index, MSB first: 7 - t/2.
    assign bitpos = ~slot_t[3:1];

    // Run one slot of the active operation.
    always_comb begin
        shift_next    = shift_cur;
        ack_hold_next = ack_cur;
        last_ack_next = last_ack_reg;
        scl_next      = scl_reg;
        sda_next      = sda_reg;
        drive_next    = drive_reg;
        rx_next       = rx_reg;
        last_slot     = 1'b0;
        busy          = 1'b0;
        op_next       = op_reg;
        tick_next     = tick_reg;
        if (slot_op != OP_IDLE) begin
            busy = 1'b1;
            unique case (slot_op)
                OP_START: begin
                    scl_next   = 1'b1;
                    drive_next = 1'b1;
                    if (slot_t == TICK_FIRST) begin
                        sda_next = 1'b1;
                    end else begin
                        sda_next  = 1'b0;
                        last_slot = 1'b1;
                    end
                end
                OP_STOP: begin
                    scl_next   = 1'b1;
                    drive_next = 1'b1;
                    if (slot_t == TICK_FIRST) begin
                        sda_next = 1'b0;
                    end else begin
                        sda_next  = 1'b1;
                        last_slot = 1'b1;
                    end
                end
                OP_WRITE: begin
                    if (slot_t < TICK_ACK_LOW) begin
                        if (!slot_t[0]) begin
                            scl_next   = 1'b0;
                            drive_next = 1'b1;
                            sda_next   = shift_cur[bitpos];
                        end else begin
                            scl_next = 1'b1;
                        end
                    end else if (slot_t == TICK_ACK_LOW) begin
                        scl_next   = 1'b0;
                        drive_next = 1'b0;
                        sda_next   = 1'b1;
                    end else if (slot_t == TICK_ACK_HIGH) begin
                        scl_next      = 1'b1;
                        last_ack_next = sda_sample;
                    end else begin
                        scl_next   = 1'b0;
                        drive_next = 1'b1;
                        sda_next   = 1'b1;
                        last_slot  = 1'b1;
                    end
                end
                OP_READ: begin
                    if (slot_t < TICK_ACK_LOW) begin
                        if (!slot_t[0]) begin
                            scl_next   = 1'b0;
                            drive_next = 1'b0;
                            sda_next   = 1'b1;
                        end else begin
                            scl_next   = 1'b1;
                            shift_next = shift_cur |
                                         (BYTE_W'(sda_sample) << bitpos);
                        end
                    end else if (slot_t == TICK_ACK_LOW) begin
                        scl_next   = 1'b0;
                        drive_next = 1'b1;
                        sda_next   = ack_cur;
                    end else if (slot_t == TICK_ACK_HIGH) begin
                        scl_next = 1'b1;
                    end else begin
                        scl_next   = 1'b0;
                        drive_next = 1'b1;
                        sda_next   = 1'b1;
                        rx_next    = shift_cur;
                        last_slot  = 1'b1;
                    end
                end
                default: begin
                    last_slot = 1'b1;
                end
            endcase
            if (last_slot) begin
                op_next   = OP_IDLE;
                tick_next = TICK_FIRST;
            end else begin
                op_next   = slot_op;
                tick_next = slot_t + TICK_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg       <= OP_IDLE;
            tick_reg     <= '0;
            shift_reg    <= '0;
            ack_hold_reg <= 1'b0;
            last_ack_reg <= 1'b0;
            scl_reg      <= 1'b1;
            sda_reg      <= 1'b1;
            drive_reg    <= 1'b1;
            rx_reg       <= '0;
        end else if (en) begin
            op_reg       <= op_next;
            tick_reg     <= tick_next;
            shift_reg    <= shift_next;
            ack_hold_reg <= ack_hold_next;
            last_ack_reg <= last_ack_next;
            scl_reg      <= scl_next;
            sda_reg      <= sda_next;
            drive_reg    <= drive_next;
            rx_reg       <= rx_next;
        end
    end

    always_comb begin
        res.scl_level    = scl_next;
        res.sda_drive    = drive_next;
        res.sda_level    = sda_next;
        res.busy_res     = busy;
        res.done_res     = last_slot;
        res.rx_byte      = rx_next;
        res.ack_received = last_ack_next;
        res.cmd_rejected = rejected;
    end

endmodule

FILE: hdl/i2c_master_bit_engine.sv
`timescale 1ns / 1ps
// I2C master line engine, one bus timing tick per request.
// Input channel (s_*): each request is one tick carrying the sampled SDA
// level and, while the engine is idle, an optional command in s_func:
// start, stop, write byte (s_tx_byte) or read byte (s_ack_to_send drives
// the acknowledge slot). A command that arrives while busy is dropped and
// flagged by m_cmd_rejected. Start and stop take 2 ticks, write and read 19.
// Result channel (m_*): exactly one result per request, giving the SCL
// level, the SDA drive enable and level, busy/done status, the last read
// byte and the last write acknowledge.
// Path: a request is held in the input register, and its result is
// registered in the result register, which drives m_*. Throughput is
// one request per cycle while m_ready is high; the engine state steps as
// each request moves into the result register.
// Stall: when m_ready is low the result register holds, the input register
// keeps at most one more request, and s_ready drops until space frees up.
// Reset (aresetn low, synchronous): both lines idle high with SDA driven,
// no operation in progress, both stages empty.
module i2c_master_bit_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [i2c_me_pkg::FUNC_W-1:0] s_func,
    input  logic [i2c_me_pkg::BYTE_W-1:0] s_tx_byte,
    input  logic                          s_ack_to_send,
    input  logic                          s_sda_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_scl_level,
    output logic                          m_sda_drive,
    output logic                          m_sda_level,
    output logic                          m_busy_res,
    output logic                          m_done_res,
    output logic [i2c_me_pkg::BYTE_W-1:0] m_rx_byte,
    output logic                          m_ack_received,
    output logic                          m_cmd_rejected
);
    import i2c_me_pkg::*;

    // Input stage: one request waiting for the engine.
    logic              in_valid_reg;
    logic [FUNC_W-1:0] func_reg;
    logic [BYTE_W-1:0] tx_reg;
    logic              ack_to_send_reg;
    logic              sda_sample_reg;

    // Result stage.
    logic              out_valid_reg;
    res_t              res_reg;
    res_t              res_comb;

    logic              advance;
    logic              s_take;

    // Move the held request into the result register when that slot is
    // free or being emptied this cycle; the engine state steps with it.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            func_reg        <= s_func;
            tx_reg          <= s_tx_byte;
            ack_to_send_reg <= s_ack_to_send;
            sda_sample_reg  <= s_sda_sample;
        end
    end

    i2c_me_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (advance),
        .func        (func_reg),
        .tx_byte     (tx_reg),
        .ack_to_send (ack_to_send_reg),
        .sda_sample  (sda_sample_reg),
        .res         (res_comb)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Hold the result while the receiver stalls.
    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_comb;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_scl_level    = res_reg.scl_level;
    assign m_sda_drive    = res_reg.sda_drive;
    assign m_sda_level    = res_reg.sda_level;
    assign m_busy_res     = res_reg.busy_res;
    assign m_done_res     = res_reg.done_res;
    assign m_rx_byte      = res_reg.rx_byte;
    assign m_ack_received = res_reg.ack_received;
    assign m_cmd_rejected = res_reg.cmd_rejected;

endmodule

FILE: hdl/i2c_me_checker.sv
`timescale 1ns / 1ps

module i2c_me_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [i2c_me_pkg::FUNC_W-1:0] s_func,
    input logic [i2c_me_pkg::BYTE_W-1:0] s_tx_byte,
    input logic                          s_ack_to_send,
    input logic                          s_sda_sample,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic                          m_scl_level,
    input logic                          m_sda_drive,
    input logic                          m_sda_level,
    input logic                          m_busy_res,
    input logic                          m_done_res,
    input logic [i2c_me_pkg::BYTE_W-1:0] m_rx_byte,
    input logic                          m_ack_received,
    input logic                          m_cmd_rejected
);

    // A finished operation was also running on that tick.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> m_busy_res)
        else $error("done without busy");

    // A rejected command implies an operation was in progress.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_cmd_rejected |-> m_busy_res)
        else $error("command rejected while idle");

    // Every operation ends with SDA driven by the master.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> m_sda_drive)
        else $error("operation ended with SDA released");

    // The read byte changes only on the final tick of an operation.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && $past(m_valid && m_ready && aresetn) &&
        (m_rx_byte != $past(m_rx_byte)) |-> m_done_res)
        else $error("rx byte changed outside a final tick");

    // A stalled result stays offered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result withdrawn under stall");

endmodule

bind i2c_master_bit_engine i2c_me_checker u_i2c_me_checker (.*);
